// ----- rtl/core/fre_pkg.sv -----
package fre_pkg;

  localparam int unsigned DATA_W        = 16;
  localparam int unsigned LINE_W        = 8;
  localparam int unsigned ACTION_W      = 4;
  localparam int unsigned REG_IDX_W     = 2;
  localparam int unsigned NUM_REGS      = 4;
  localparam int unsigned PROGRAM_LINES = 128;

  typedef enum logic [ACTION_W-1:0] {
    ACT_MOV   = 4'd0,
    ACT_ADD   = 4'd1,
    ACT_SUB   = 4'd2,
    ACT_MUL   = 4'd3,
    ACT_DIV   = 4'd4,
    ACT_JMP   = 4'd5,
    ACT_JE    = 4'd6,
    ACT_JNE   = 4'd7,
    ACT_JG    = 4'd8,
    ACT_JGE   = 4'd9,
    ACT_JL    = 4'd10,
    ACT_JLE   = 4'd11,
    ACT_READ  = 4'd12,
    ACT_PRINT = 4'd13,
    ACT_BLANK = 4'd14
  } action_e;

  typedef struct packed {
    logic [ACTION_W-1:0]      action;
    logic                     first_is_immediate;
    logic [REG_IDX_W-1:0]     first_register;
    logic signed [DATA_W-1:0] first_immediate;
    logic                     second_is_immediate;
    logic [REG_IDX_W-1:0]     second_register;
    logic signed [DATA_W-1:0] second_immediate;
    logic [REG_IDX_W-1:0]     target_register;
    logic [LINE_W-1:0]        jump_line;
    logic signed [DATA_W-1:0] read_value;
  } in_word_t;

  typedef struct packed {
    logic [LINE_W-1:0]        next_line;
    logic                     print_valid;
    logic signed [DATA_W-1:0] print_value;
    logic                     divide_by_zero;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_instr;
    logic start_div;
    logic div_step;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
    logic div_last;
  } status_t;

endpackage

// ----- rtl/core/fre_stream_if.sv -----
interface fre_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/fre_datapath.sv -----
module fre_datapath #(
  parameter int unsigned ProgramLines = fre_pkg::PROGRAM_LINES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fre_pkg::in_word_t   instr_i,
  input  fre_pkg::cmd_t       cmd_i,
  output fre_pkg::status_t    status_o,
  output fre_pkg::out_word_t  out_word_o
);

  localparam int unsigned DW   = fre_pkg::DATA_W;
  localparam int unsigned LW   = fre_pkg::LINE_W;
  localparam int unsigned CntW = $clog2(DW);
  localparam logic [LW-1:0]   EndLine = LW'(ProgramLines);
  localparam logic [CntW-1:0] LastStep = CntW'(DW - 1);

  fre_pkg::in_word_t  instr_q;
  fre_pkg::out_word_t out_q;

  logic signed [DW-1:0] rf_mem [fre_pkg::NUM_REGS];
  logic                 rf_vld_q [fre_pkg::NUM_REGS];
  logic signed [DW-1:0] rd_a_q, rd_b_q;
  logic [fre_pkg::REG_IDX_W-1:0] rd_b_addr;

  logic [LW-1:0]   line_q;
  logic [DW-1:0]   quo_q, rem_q, dvs_q;
  logic [CntW-1:0] cnt_q;

  fre_pkg::action_e     act;
  logic                 ended;
  logic signed [DW-1:0] op_x, op_d, op_y, prod, quo_signed;
  logic [DW-1:0]        x_mag, d_mag;
  logic [DW:0]          rem_sh, diff;

  logic                 wr_en, taken, pv, dz;
  logic signed [DW-1:0] wr_val, pval;
  logic [LW:0]          next_wide;
  logic [LW-1:0]        next_line;

  // A compare jump has no target, so the second read port serves its second operand.
  always_comb begin
    if (instr_i.action >= fre_pkg::ACT_JE && instr_i.action <= fre_pkg::ACT_JLE) begin
      rd_b_addr = instr_i.second_register;
    end else begin
      rd_b_addr = instr_i.target_register;
    end
  end

  assign act   = fre_pkg::action_e'(instr_q.action);
  assign ended = (line_q >= EndLine);

  assign op_x = instr_q.first_is_immediate ? instr_q.first_immediate : rd_a_q;
  assign op_d = rd_b_q;
  assign op_y = instr_q.second_is_immediate ? instr_q.second_immediate : rd_b_q;

  assign x_mag = op_x[DW-1] ? DW'(~op_x + 1'b1) : DW'(op_x);
  assign d_mag = op_d[DW-1] ? DW'(~op_d + 1'b1) : DW'(op_d);
  assign prod  = op_x * op_d;
  assign quo_signed = (op_x[DW-1] ^ op_d[DW-1]) ? DW'(~quo_q + 1'b1) : quo_q;

  assign rem_sh = {rem_q, quo_q[DW-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_comb begin
    wr_en  = 1'b0;
    wr_val = op_x;
    taken  = 1'b0;
    pv     = 1'b0;
    pval   = '0;
    dz     = 1'b0;
    unique case (act)
      fre_pkg::ACT_MOV: wr_en = 1'b1;
      fre_pkg::ACT_ADD: begin
        wr_en  = 1'b1;
        wr_val = op_d + op_x;
      end
      fre_pkg::ACT_SUB: begin
        wr_en  = 1'b1;
        wr_val = op_d - op_x;
      end
      fre_pkg::ACT_MUL: begin
        wr_en  = 1'b1;
        wr_val = prod;
      end
      fre_pkg::ACT_DIV: begin
        wr_en = 1'b1;
        if (op_d == '0) begin
          wr_val = '0;
          dz     = 1'b1;
        end else begin
          wr_val = quo_signed;
        end
      end
      fre_pkg::ACT_JMP:  taken = 1'b1;
      fre_pkg::ACT_JE:   taken = (op_x == op_y);
      fre_pkg::ACT_JNE:  taken = (op_x != op_y);
      fre_pkg::ACT_JG:   taken = (op_x > op_y);
      fre_pkg::ACT_JGE:  taken = (op_x >= op_y);
      fre_pkg::ACT_JL:   taken = (op_x < op_y);
      fre_pkg::ACT_JLE:  taken = (op_x <= op_y);
      fre_pkg::ACT_READ: begin
        wr_en  = 1'b1;
        wr_val = instr_q.read_value;
      end
      fre_pkg::ACT_PRINT: begin
        pv   = 1'b1;
        pval = op_x;
      end
      default: ;
    endcase

    // A taken jump to its own line falls through.
    if (taken && instr_q.jump_line != line_q) begin
      next_wide = {1'b0, instr_q.jump_line};
    end else begin
      next_wide = {1'b0, line_q} + 1'b1;
    end
    if (next_wide > {1'b0, EndLine}) begin
      next_line = EndLine;
    end else begin
      next_line = next_wide[LW-1:0];
    end

    // Past the end of the program the instruction has no effect.
    if (ended) begin
      next_line = EndLine;
      wr_en     = 1'b0;
      pv        = 1'b0;
      pval      = '0;
      dz        = 1'b0;
    end
  end

  assign status_o.need_div = (act == fre_pkg::ACT_DIV) && !ended && (op_d != '0);
  assign status_o.div_last = (cnt_q == LastStep);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0;
      cnt_q  <= '0;
      for (int i = 0; i < fre_pkg::NUM_REGS; i++) begin
        rf_vld_q[i] <= 1'b0;
      end
    end else begin
      if (cmd_i.commit) begin
        line_q <= next_line;
        if (wr_en) begin
          rf_vld_q[instr_q.target_register] <= 1'b1;
        end
      end
      if (cmd_i.start_div) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_instr) begin
      instr_q <= instr_i;
      rd_a_q  <= rf_vld_q[instr_i.first_register] ? rf_mem[instr_i.first_register] : '0;
      rd_b_q  <= rf_vld_q[rd_b_addr] ? rf_mem[rd_b_addr] : '0;
    end
    if (cmd_i.commit && wr_en) begin
      rf_mem[instr_q.target_register] <= wr_val;
    end
    if (cmd_i.commit) begin
      out_q.next_line      <= next_line;
      out_q.print_valid    <= pv;
      out_q.print_value    <= pval;
      out_q.divide_by_zero <= dz;
    end
    // Restoring division on magnitudes, one quotient bit per cycle.
    if (cmd_i.start_div) begin
      quo_q <= x_mag;
      rem_q <= '0;
      dvs_q <= d_mag;
    end else if (cmd_i.div_step) begin
      if (!diff[DW]) begin
        rem_q <= diff[DW-1:0];
        quo_q <= {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DW-1:0];
        quo_q <= {quo_q[DW-2:0], 1'b0};
      end
    end
  end

  assign out_word_o = out_q;

endmodule

// ----- rtl/core/fre_ctrl.sv -----
module fre_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  fre_pkg::status_t status_i,
  output fre_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_DIVIDE = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  // The output register can take a new word when empty or emptying this cycle.
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_instr = 1'b1;
          state_d           = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.need_div) begin
          cmd_o.start_div = 1'b1;
          state_d         = ST_DIVIDE;
        end else if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_commit_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || out_ready_i))
    else $error("result committed over an untaken word");

  a_commit_shows_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("committed result not presented");

  a_accept_starts_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_EXEC))
    else $error("accepted word did not start execution");

  a_div_ends_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE && status_i.div_last) |=> (state_q == ST_FINISH))
    else $error("divider ran past its last step");

endmodule

// ----- rtl/core/four_register_instruction_execute_top.sv -----
// Executes one pre-decoded instruction per input word on a machine with four
// 16-bit signed registers and a program line counter, and returns one result
// word per instruction carrying the next line to fetch, an optional printed
// value and a divide-by-zero flag. Instructions are handled one at a time: a
// move, add, subtract, multiply, jump, read, print or blank is latched, then
// executed and written to the output register. A divide with a nonzero divisor
// passes through the restoring divider first, which produces one quotient bit
// per cycle. The next word is accepted as soon as the previous result is
// registered, even while that result still waits to be taken; only when the
// output register is still full at the end of an instruction does execution
// hold. The register file resets to zero and the line counter to line zero.
// Once the counter reaches ProgramLines every further instruction is ignored
// and reports ProgramLines as the next line.
module four_register_instruction_execute_top #(
  parameter int unsigned ProgramLines = fre_pkg::PROGRAM_LINES
) (
  input logic          clk_i,
  input logic          rst_ni,
  fre_stream_if.sink   in_i,
  fre_stream_if.source out_o
);

  fre_pkg::cmd_t      cmd;
  fre_pkg::status_t   status;
  fre_pkg::out_word_t out_word;

  // The controller sequences fetch, execute, divide and commit.
  fre_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the register file, line counter, divider and result word.
  fre_datapath #(
    .ProgramLines (ProgramLines)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .instr_i    (in_i.payload),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_word_o (out_word)
  );

  assign out_o.payload = out_word;

endmodule

// ----- bench/fre_result_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels of the instruction executor. It keeps its own copy
// of the register file and the line counter. For every accepted instruction
// word it computes the result word the block has to return, and it checks
// returned words in order.
module fre_result_checker
  import fre_pkg::*;
#(
  parameter int unsigned ProgramLines = PROGRAM_LINES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      instr_valid_i,
  input  logic      instr_ready_i,
  input  in_word_t  instr_word_i,
  input  logic      result_valid_i,
  input  logic      result_ready_i,
  input  out_word_t result_word_i,
  output int        fail_count_o,
  output int        pending_o
);

  logic signed [DATA_W-1:0] regs_q [NUM_REGS];
  logic [LINE_W-1:0]        line_q;
  out_word_t                results_due [$];

  function automatic int operand_value(logic is_imm, logic [REG_IDX_W-1:0] idx,
                                       logic signed [DATA_W-1:0] imm);
    if (is_imm) return int'(imm);
    return int'(regs_q[idx]);
  endfunction

  // Applies one instruction to the shadow state and returns its result word.
  function automatic out_word_t execute_instruction(in_word_t w);
    out_word_t   res;
    int          src;
    int          cmp;
    int          dst;
    logic        taken;
    int unsigned nxt;
    res = '0;
    if (line_q >= ProgramLines) begin
      res.next_line = LINE_W'(ProgramLines);
      return res;
    end
    src   = operand_value(w.first_is_immediate, w.first_register, w.first_immediate);
    cmp   = operand_value(w.second_is_immediate, w.second_register, w.second_immediate);
    dst   = int'(regs_q[w.target_register]);
    taken = 1'b0;
    nxt   = line_q + 1;
    case (w.action)
      ACT_MOV: regs_q[w.target_register] = DATA_W'(src);
      ACT_ADD: regs_q[w.target_register] = DATA_W'(src + dst);
      ACT_SUB: regs_q[w.target_register] = DATA_W'(dst - src);
      ACT_MUL: regs_q[w.target_register] = DATA_W'(src * dst);
      ACT_DIV: begin
        // The source is the dividend here; the destination is the divisor.
        if (dst == 0) begin
          regs_q[w.target_register] = '0;
          res.divide_by_zero = 1'b1;
        end else begin
          regs_q[w.target_register] = DATA_W'(src / dst);
        end
      end
      ACT_JMP:  taken = 1'b1;
      ACT_JE:   taken = (src == cmp);
      ACT_JNE:  taken = (src != cmp);
      ACT_JG:   taken = (src > cmp);
      ACT_JGE:  taken = (src >= cmp);
      ACT_JL:   taken = (src < cmp);
      ACT_JLE:  taken = (src <= cmp);
      ACT_READ: regs_q[w.target_register] = w.read_value;
      ACT_PRINT: begin
        res.print_valid = 1'b1;
        res.print_value = DATA_W'(src);
      end
      default: ;
    endcase
    // A taken jump to the line it sits on simply falls through.
    if (taken && w.jump_line != line_q) nxt = w.jump_line;
    if (nxt > ProgramLines) nxt = ProgramLines;
    line_q        = LINE_W'(nxt);
    res.next_line = LINE_W'(nxt);
    return res;
  endfunction

  task automatic record_failure(string what, out_word_t want, out_word_t got);
    fail_count_o++;
    if (fail_count_o <= 10)
      $display("%0t: %s: expected line %0d print %0b/%0d dz %0b, got line %0d print %0b/%0d dz %0b",
               $time, what, want.next_line, want.print_valid, want.print_value,
               want.divide_by_zero, got.next_line, got.print_valid, got.print_value,
               got.divide_by_zero);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      foreach (regs_q[i]) regs_q[i] = '0;
      line_q = '0;
      results_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // A result can never leave in the cycle its own instruction enters, so
      // checking outputs before predicting the new input is safe.
      if (result_valid_i && result_ready_i) begin
        if (results_due.size() == 0) begin
          record_failure("result word with nothing pending", '0, result_word_i);
        end else begin
          want = results_due.pop_front();
          if (want.next_line !== result_word_i.next_line ||
              want.print_valid !== result_word_i.print_valid ||
              want.print_value !== result_word_i.print_value ||
              want.divide_by_zero !== result_word_i.divide_by_zero)
            record_failure("result word mismatch", want, result_word_i);
        end
      end
      if (instr_valid_i && instr_ready_i)
        results_due.push_back(execute_instruction(instr_word_i));
      pending_o = results_due.size();
    end
  end

endmodule

// ----- bench/tb_four_register_instruction_execute_top.sv -----
`timescale 1ns / 100ps

// Stimulus and verdict for the four-register instruction executor. The
// checker beside the block does all prediction; this module only produces
// instruction words, paces both channels and decides the outcome.
module tb_four_register_instruction_execute_top;
  import fre_pkg::*;

  localparam int unsigned RANDOM_WORDS   = 1950;
  localparam int unsigned CYCLE_LIMIT    = 400_000;
  localparam int unsigned RX_HOLD_CYCLES = 200;
  localparam int unsigned DRAIN_CYCLES   = 30;
  // Ordinary jump targets stay low so that the program never runs off its end
  // by accident; see the bound explained in the random loop.
  localparam int unsigned JUMP_SPAN      = 80;
  localparam int unsigned MAX_RUN        = 40;

  localparam logic [ACTION_W-1:0]  ACT_SPARE = 4'd15;
  localparam logic                 USE_IMM   = 1'b1;
  localparam logic                 USE_REG   = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_A     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_B     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_C     = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_D     = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int          items_sent = 0;
  logic        rx_hold = 1'b0;
  int unsigned cycle_count = 0;
  int          fail_count;
  int          pending;

  fre_stream_if #(.payload_t(in_word_t))  instr_if ();
  fre_stream_if #(.payload_t(out_word_t)) result_if ();

  always #5 clk_i = ~clk_i;

  four_register_instruction_execute_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (instr_if),
    .out_o (result_if)
  );

  fre_result_checker checker_u (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .instr_valid_i (instr_if.valid),
    .instr_ready_i (instr_if.ready),
    .instr_word_i  (instr_if.payload),
    .result_valid_i(result_if.valid),
    .result_ready_i(result_if.ready),
    .result_word_i (result_if.payload),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Data values lean toward the corners: the most negative and most positive
  // values, zero (which feeds divide-by-zero), one and minus one.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sd0;
      3: return 16'sd1;
      4: return -16'sd1;
      5: return DATA_W'($urandom_range(15));
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic in_word_t make_word(logic [ACTION_W-1:0] act, logic fi,
                                         logic [REG_IDX_W-1:0] fr,
                                         logic signed [DATA_W-1:0] fv, logic si,
                                         logic [REG_IDX_W-1:0] sr,
                                         logic signed [DATA_W-1:0] sv,
                                         logic [REG_IDX_W-1:0] tgt,
                                         logic [LINE_W-1:0] jl,
                                         logic signed [DATA_W-1:0] rv);
    in_word_t w;
    w.action              = act;
    w.first_is_immediate  = fi;
    w.first_register      = fr;
    w.first_immediate     = fv;
    w.second_is_immediate = si;
    w.second_register     = sr;
    w.second_immediate    = sv;
    w.target_register     = tgt;
    w.jump_line           = jl;
    w.read_value          = rv;
    return w;
  endfunction

  // Every field random; the caller then picks the action and, if needed,
  // adjusts the jump target.
  function automatic in_word_t random_fields();
    return make_word(ACT_BLANK, 1'($urandom_range(1)), REG_IDX_W'($urandom_range(3)),
                     pick_value(), 1'($urandom_range(1)), REG_IDX_W'($urandom_range(3)),
                     pick_value(), REG_IDX_W'($urandom_range(3)),
                     LINE_W'($urandom_range(JUMP_SPAN)), pick_value());
  endfunction

  // Whether a compare on two known immediates succeeds. Used only to know
  // when a jump target may safely point past the program.
  function automatic bit compare_holds(logic [ACTION_W-1:0] act, int x, int y);
    case (act)
      ACT_JE:  return x == y;
      ACT_JNE: return x != y;
      ACT_JG:  return x > y;
      ACT_JGE: return x >= y;
      ACT_JL:  return x < y;
      ACT_JLE: return x <= y;
      default: return 1'b1;
    endcase
  endfunction

  // Offers one word starting at a falling edge and returns at the falling
  // edge after it was taken. Valid is assigned at most once per falling edge.
  task automatic send_word(in_word_t w);
    while (!(items_sent >= 700 && items_sent < 1000) && $urandom_range(99) < 24) begin
      instr_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    instr_if.valid   <= 1'b1;
    instr_if.payload <= w;
    @(posedge clk_i);
    while (!instr_if.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Result side: random back-pressure, a quiet stretch with the sink always
  // ready, and one long hold-off while the sender keeps offering words.
  initial begin
    result_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      result_if.ready <= !rx_hold &&
                         ((items_sent >= 1100 && items_sent < 1400) ||
                          $urandom_range(99) >= 24);
    end
  end

  // The hold-off is counted here in clock cycles. The flag changes on rising
  // edges so that the receiver reads a settled value at the falling edge.
  initial begin
    wait (items_sent >= 400);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Watchdog. A run that hangs or leaves a result owed ends here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    in_word_t w;
    int       since_jump;
    int       self_line;
    int       roll;
    rst_ni           = 1'b0;
    instr_if.valid   = 1'b0;
    instr_if.payload = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part. The comment on each word gives the line it executes on.
    // Line 0: divide with a zero divisor, register a is still zero.
    send_word(make_word(ACT_DIV, USE_REG, REG_A, 16'sd0, USE_REG, REG_A, 16'sd0,
                        REG_A, 8'd0, 16'sd0));
    // Lines 1-3: a = most negative, b = -1, then b = a / b must wrap back to
    // the most negative value.
    send_word(make_word(ACT_READ, USE_REG, REG_A, 16'sd0, USE_REG, REG_A, 16'sd0,
                        REG_A, 8'd0, 16'sh8000));
    send_word(make_word(ACT_READ, USE_REG, REG_A, 16'sd0, USE_REG, REG_A, 16'sd0,
                        REG_B, 8'd0, -16'sd1));
    send_word(make_word(ACT_DIV, USE_REG, REG_A, 16'sd0, USE_REG, REG_A, 16'sd0,
                        REG_B, 8'd0, 16'sd0));
    // Lines 4-8: the remaining arithmetic, each one wrapping at the extremes.
    send_word(make_word(ACT_READ, USE_REG, REG_A, 16'sd0, USE_REG, REG_A, 16'sd0,
                        REG_C, 8'd0, 16'sh7fff));
    send_word(make_word(ACT_MOV, USE_IMM, REG_A, 16'sh7fff, USE_REG, REG_A, 16'sd0,
                        REG_D, 8'd0, 16'sd0));
    send_word(make_word(ACT_ADD, USE_REG, REG_C, 16'sd0, USE_REG, REG_A, 16'sd0,
                        REG_D, 8'd0, 16'sd0));
    send_word(make_word(ACT_SUB, USE_IMM, REG_A, 16'sh8000, USE_REG, REG_A, 16'sd0,
                        REG_C, 8'd0, 16'sd0));
    send_word(make_word(ACT_MUL, USE_REG, REG_D, 16'sd0, USE_REG, REG_A, 16'sd0,
                        REG_A, 8'd0, 16'sd0));
    // Lines 9-10: print a register, then the most negative immediate.
    send_word(make_word(ACT_PRINT, USE_REG, REG_C, 16'sd0, USE_REG, REG_A, 16'sd0,
                        REG_A, 8'd0, 16'sd0));
    send_word(make_word(ACT_PRINT, USE_IMM, REG_A, 16'sh8000, USE_REG, REG_A, 16'sd0,
                        REG_A, 8'd0, 16'sd0));
    // Line 11 jumps to 20, where a jump to its own line must fall through.
    send_word(make_word(ACT_JMP, USE_REG, REG_A, 16'sd0, USE_REG, REG_A, 16'sd0,
                        REG_A, 8'd20, 16'sd0));
    send_word(make_word(ACT_JMP, USE_REG, REG_A, 16'sd0, USE_REG, REG_A, 16'sd0,
                        REG_A, 8'd20, 16'sd0));
    // Lines 21, 30, 31, 40, 41: each compare, taken and not taken, mixing
    // register and immediate operands.
    send_word(make_word(ACT_JE, USE_IMM, REG_A, 16'sd5, USE_IMM, REG_A, 16'sd5,
                        REG_A, 8'd30, 16'sd0));
    send_word(make_word(ACT_JNE, USE_REG, REG_B, 16'sd0, USE_REG, REG_B, 16'sd0,
                        REG_A, 8'd90, 16'sd0));
    send_word(make_word(ACT_JG, USE_IMM, REG_A, 16'sh7fff, USE_IMM, REG_A, 16'sh8000,
                        REG_A, 8'd40, 16'sd0));
    send_word(make_word(ACT_JGE, USE_REG, REG_C, 16'sd0, USE_IMM, REG_A, 16'sd0,
                        REG_A, 8'd90, 16'sd0));
    send_word(make_word(ACT_JL, USE_IMM, REG_A, 16'sh8000, USE_REG, REG_D, 16'sd0,
                        REG_A, 8'd2, 16'sd0));
    // Line 2: a taken conditional jump to its own line also falls through.
    send_word(make_word(ACT_JLE, USE_REG, REG_D, 16'sd0, USE_REG, REG_D, 16'sd0,
                        REG_A, 8'd2, 16'sd0));
    // Lines 3-4: an ordinary divide with a nonzero divisor and a negative
    // dividend, which has to truncate toward zero.
    send_word(make_word(ACT_READ, USE_REG, REG_A, 16'sd0, USE_REG, REG_A, 16'sd0,
                        REG_D, 8'd0, 16'sd7));
    send_word(make_word(ACT_DIV, USE_IMM, REG_A, -16'sd100, USE_REG, REG_A, 16'sd0,
                        REG_D, 8'd0, 16'sd0));
    // Lines 5-7: blank, the unused action code, and a compare that is not
    // taken although its target lies far past the program.
    send_word(make_word(ACT_BLANK, USE_REG, REG_A, 16'sd0, USE_REG, REG_A, 16'sd0,
                        REG_A, 8'd0, 16'sd0));
    send_word(make_word(ACT_SPARE, USE_REG, REG_A, 16'sd0, USE_REG, REG_A, 16'sd0,
                        REG_A, 8'd0, 16'sd0));
    send_word(make_word(ACT_JNE, USE_IMM, REG_A, 16'sd0, USE_IMM, REG_A, 16'sd0,
                        REG_A, 8'd255, 16'sd0));

    // Random part. Every taken jump lands at or below JUMP_SPAN + 1, and an
    // unconditional jump is forced at least every MAX_RUN words, so the line
    // counter stays below the program length until the final words.
    since_jump = 0;
    self_line  = -1;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      w = random_fields();
      if (self_line >= 0) begin
        // Repeat the previous jump target: usually this is a jump to its own
        // line.
        w.action    = ACT_JMP;
        w.jump_line = LINE_W'(self_line);
        self_line   = -1;
        since_jump  = 0;
      end else if (since_jump >= MAX_RUN || $urandom_range(99) < 6) begin
        w.action   = ACT_JMP;
        since_jump = 0;
        if ($urandom_range(3) == 0) self_line = int'(w.jump_line);
      end else begin
        roll = $urandom_range(99);
        if (roll < 16) begin
          w.action = ACTION_W'(ACT_JE + $urandom_range(ACT_JLE - ACT_JE));
          // A compare of two immediates that is known to fail may point
          // anywhere, which also reaches the upper target bits.
          if (w.first_is_immediate && w.second_is_immediate &&
              !compare_holds(w.action, int'(w.first_immediate),
                             int'(w.second_immediate)))
            w.jump_line = LINE_W'($urandom_range(255));
        end else if (roll < 30) begin
          w.action = ACT_READ;
        end else if (roll < 40) begin
          w.action = ACT_PRINT;
        end else if (roll < 46) begin
          w.action = $urandom_range(1) ? ACT_SPARE : ACT_BLANK;
        end else begin
          w.action = ACTION_W'(ACT_MOV + $urandom_range(ACT_DIV - ACT_MOV));
        end
        since_jump++;
      end
      send_word(w);
    end

    // Ending: a jump far past the program saturates the next line at the
    // program length, and the words after it must all be ignored.
    send_word(make_word(ACT_JMP, USE_REG, REG_A, 16'sd0, USE_REG, REG_A, 16'sd0,
                        REG_A, 8'd250, 16'sd0));
    send_word(make_word(ACT_PRINT, USE_IMM, REG_A, 16'sh7fff, USE_REG, REG_A, 16'sd0,
                        REG_A, 8'd0, 16'sd0));
    send_word(make_word(ACT_DIV, USE_REG, REG_A, 16'sd0, USE_REG, REG_A, 16'sd0,
                        REG_B, 8'd0, 16'sd0));
    send_word(make_word(ACT_READ, USE_REG, REG_A, 16'sd0, USE_REG, REG_A, 16'sd0,
                        REG_C, 8'd0, 16'sd9));
    send_word(make_word(ACT_JMP, USE_REG, REG_A, 16'sd0, USE_REG, REG_A, 16'sd0,
                        REG_A, 8'd3, 16'sd0));
    instr_if.valid <= 1'b0;

    // Drain. The watchdog covers a result that never arrives; the extra
    // cycles catch a stray result after the last expected one.
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
